@@ hw/rtl/irl_pkg.sv @@
// Shared constants, widths and types for the IR range-sensor linearizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package irl_pkg;

  localparam int SAMPLE_BITS = 10;

  localparam int SHORT_OFFSET = 35;
  localparam int SHORT_NUM    = 489552;
  localparam int SHORT_SUB    = 84;
  localparam int SHORT_DEN    = 10;
  localparam int SHORT_MIN    = 40;
  localparam int SHORT_MAX    = 350;

  localparam int LONG_OFFSET = 23;
  localparam int LONG_NUM    = 150000;
  localparam int LONG_ADD    = 15;
  localparam int LONG_DEN    = 2;
  localparam int LONG_MIN    = 100;
  localparam int LONG_MAX    = 800;

  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int SHORT_NUM_MAX = SHORT_NUM - SHORT_SUB * SHORT_OFFSET;
  localparam int LONG_NUM_MAX  = LONG_NUM + LONG_ADD * (SAMPLE_MAX - LONG_OFFSET);
  localparam int NUM_MAX       = (SHORT_NUM_MAX > LONG_NUM_MAX) ? SHORT_NUM_MAX : LONG_NUM_MAX;

  localparam int NUM_W  = $clog2(NUM_MAX + 1);
  localparam int DEN_W  = $clog2(SHORT_DEN * (SAMPLE_MAX + SHORT_OFFSET) + 1);
  localparam int QUO_W  = $clog2(LONG_MAX + 1);
  localparam int PROD_W = DEN_W + QUO_W;

  localparam int SHORT_MM_W = 9;
  localparam int LONG_MM_W  = 10;

  localparam int IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * SHORT_MM_W + LONG_MM_W + 7) / 8) * 8;

  // prep register plus one register per quotient bit
  localparam int NSTG = QUO_W + 1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [NUM_W-1:0]       num_t;
  typedef logic [DEN_W-1:0]       den_t;
  typedef logic [QUO_W-1:0]       quo_t;

  typedef struct packed {
    num_t num;
    den_t den;
    logic sat;
  } div_req_t;

endpackage

@@ hw/rtl/irl_short_prep.sv @@
// Front stage of a short-range lane: forms numerator, denominator and upper saturation.
// Depends on irl_pkg.
`timescale 1ns / 1ps

module irl_short_prep (
  input  logic              clk_i,
  input  logic              en_i,
  input  irl_pkg::sample_t  sample_i,
  output irl_pkg::div_req_t req_o
);
  import irl_pkg::*;

  logic [SAMPLE_BITS:0] biased;
  num_t                 num;
  den_t                 den;
  logic [PROD_W-1:0]    lim;
  div_req_t             req_d, req_q;

  assign biased = {1'b0, sample_i} + (SAMPLE_BITS + 1)'(SHORT_OFFSET);
  assign num    = NUM_W'(SHORT_NUM - SHORT_SUB * int'(biased));
  assign den    = DEN_W'(SHORT_DEN * int'(biased));
  assign lim    = PROD_W'(den) * PROD_W'(SHORT_MAX + 1);

  always_comb begin
    req_d.num = num;
    req_d.den = den;
    req_d.sat = (PROD_W'(num) >= lim);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

@@ hw/rtl/irl_long_prep.sv @@
// Front stage of the long-range lane: forms numerator, denominator and saturation.
// Depends on irl_pkg.
`timescale 1ns / 1ps

module irl_long_prep (
  input  logic              clk_i,
  input  logic              en_i,
  input  irl_pkg::sample_t  sample_i,
  output irl_pkg::div_req_t req_o
);
  import irl_pkg::*;

  logic              near;
  sample_t           excess;
  num_t              num;
  den_t              den;
  logic [PROD_W-1:0] lim;
  div_req_t          req_d, req_q;

  assign near   = (sample_i <= SAMPLE_BITS'(LONG_OFFSET));
  assign excess = sample_i - SAMPLE_BITS'(LONG_OFFSET);
  assign num    = NUM_W'(LONG_NUM + LONG_ADD * int'(excess));
  assign den    = DEN_W'(LONG_DEN * int'(excess));
  assign lim    = PROD_W'(den) * PROD_W'(LONG_MAX + 1);

  always_comb begin
    req_d.num = num;
    req_d.den = den;
    req_d.sat = near || (PROD_W'(num) >= lim);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

@@ hw/rtl/irl_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturation flag carried along.
// Depends on irl_pkg.
`timescale 1ns / 1ps

module irl_div (
  input  logic                     clk_i,
  input  logic [irl_pkg::QUO_W-1:0] en_i,
  input  irl_pkg::div_req_t        req_i,
  output irl_pkg::quo_t            quo_o,
  output logic                     sat_o
);
  import irl_pkg::*;

  num_t rem_q [QUO_W];
  den_t den_q [QUO_W];
  quo_t quo_q [QUO_W];
  logic sat_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;

    num_t              rem_in, rem_nx;
    den_t              den_in;
    quo_t              quo_in, quo_nx;
    logic              sat_in;
    logic [PROD_W-1:0] trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = req_i.num;
      assign den_in = req_i.den;
      assign quo_in = '0;
      assign sat_in = req_i.sat;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sat_in = sat_q[k-1];
    end

    assign trial = PROD_W'(den_in) << SH;
    assign take  = (PROD_W'(rem_in) >= trial);

    always_comb begin
      quo_nx     = quo_in;
      quo_nx[SH] = take;
      rem_nx     = take ? (rem_in - trial[NUM_W-1:0]) : rem_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_nx;
        den_q[k] <= den_in;
        quo_q[k] <= quo_nx;
        sat_q[k] <= sat_in;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
  assign sat_o = sat_q[QUO_W-1];

endmodule

@@ hw/rtl/ir_range_sensor_linearizer.sv @@
// IR range-sensor linearizer top: three divider lanes, merge and output register.
// Throughput: one transaction per cycle while the output is not stalled, set by one quotient bit per divider stage.
// Each stage holds its item until the next frees up, so bubbles collapse under stall.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data registers keep values.
// Depends on irl_pkg, irl_short_prep, irl_long_prep, irl_div.
`timescale 1ns / 1ps

module ir_range_sensor_linearizer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // right_sample, front_sample, left_sample, zero pad
  input  logic [irl_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // right_mm, front_mm, left_mm, zero pad
  output logic [irl_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import irl_pkg::*;

  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG:0]   chain;
  logic            out_vld_q, out_vld_d;
  logic            out_rdy;

  sample_t  right_s, front_s, left_s;
  div_req_t right_req, front_req, left_req;
  quo_t     right_quo, front_quo, left_quo;
  logic     right_sat, front_sat, left_sat;

  logic [SHORT_MM_W-1:0] right_mm_d, right_mm_q, left_mm_d, left_mm_q;
  logic [LONG_MM_W-1:0]  front_mm_d, front_mm_q;

  assign right_s = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign front_s = s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign left_s  = s_axis_tdata_i[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  assign out_rdy = !out_vld_q || m_axis_tready_i;

  always_comb begin
    chain[NSTG] = out_rdy;
    for (int i = NSTG - 1; i >= 0; i--) begin
      chain[i] = !vld_q[i] || chain[i+1];
    end
    for (int i = 0; i < NSTG; i++) begin
      if (chain[i]) begin
        vld_d[i] = (i == 0) ? s_axis_tvalid_i : vld_q[(i == 0) ? 0 : i - 1];
      end else begin
        vld_d[i] = vld_q[i];
      end
    end
    out_vld_d = out_rdy ? vld_q[NSTG-1] : out_vld_q;
  end

  assign s_axis_tready_o = chain[0];

  irl_short_prep u_right_prep (
    .clk_i   (clk_i),
    .en_i    (chain[0]),
    .sample_i(right_s),
    .req_o   (right_req)
  );

  irl_long_prep u_front_prep (
    .clk_i   (clk_i),
    .en_i    (chain[0]),
    .sample_i(front_s),
    .req_o   (front_req)
  );

  irl_short_prep u_left_prep (
    .clk_i   (clk_i),
    .en_i    (chain[0]),
    .sample_i(left_s),
    .req_o   (left_req)
  );

  irl_div u_right_div (
    .clk_i(clk_i),
    .en_i (chain[NSTG-1:1]),
    .req_i(right_req),
    .quo_o(right_quo),
    .sat_o(right_sat)
  );

  irl_div u_front_div (
    .clk_i(clk_i),
    .en_i (chain[NSTG-1:1]),
    .req_i(front_req),
    .quo_o(front_quo),
    .sat_o(front_sat)
  );

  irl_div u_left_div (
    .clk_i(clk_i),
    .en_i (chain[NSTG-1:1]),
    .req_i(left_req),
    .quo_o(left_quo),
    .sat_o(left_sat)
  );

  // clamp each lane into its range
  always_comb begin
    if (right_sat) begin
      right_mm_d = SHORT_MM_W'(SHORT_MAX);
    end else if (right_quo < QUO_W'(SHORT_MIN)) begin
      right_mm_d = SHORT_MM_W'(SHORT_MIN);
    end else begin
      right_mm_d = right_quo[SHORT_MM_W-1:0];
    end

    if (left_sat) begin
      left_mm_d = SHORT_MM_W'(SHORT_MAX);
    end else if (left_quo < QUO_W'(SHORT_MIN)) begin
      left_mm_d = SHORT_MM_W'(SHORT_MIN);
    end else begin
      left_mm_d = left_quo[SHORT_MM_W-1:0];
    end

    if (front_sat) begin
      front_mm_d = LONG_MM_W'(LONG_MAX);
    end else if (front_quo < QUO_W'(LONG_MIN)) begin
      front_mm_d = LONG_MM_W'(LONG_MIN);
    end else begin
      front_mm_d = front_quo[LONG_MM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      right_mm_q <= right_mm_d;
      front_mm_q <= front_mm_d;
      left_mm_q  <= left_mm_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'({left_mm_q, front_mm_q, right_mm_q});

`ifndef SYNTH
  a_ready_low_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> ((&vld_q) && out_vld_q))
    else $error("input stalled while the pipeline has a free stage");

  a_out_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (right_mm_q >= SHORT_MM_W'(SHORT_MIN) && right_mm_q <= SHORT_MM_W'(SHORT_MAX)
                && left_mm_q >= SHORT_MM_W'(SHORT_MIN) && left_mm_q <= SHORT_MM_W'(SHORT_MAX)
                && front_mm_q >= LONG_MM_W'(LONG_MIN) && front_mm_q <= LONG_MM_W'(LONG_MAX)))
    else $error("distance outside its saturation range");

  a_out_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rdy && vld_q[NSTG-1]) |=> out_vld_q)
    else $error("finished item lost at the output register");
`endif

endmodule
